[rtl/semtab_pkg.sv]
`timescale 1ns / 1ps

package semtab_pkg;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_POST  = 2'd2,
    KIND_WAIT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_ATTACH_LIMIT = 3'd2,
    ST_TABLE_FULL   = 3'd3,
    ST_QUEUE_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] sem_id;
    logic [31:0] init_value;
    logic [15:0] caller_pid;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] handle_id;
    logic        wake_valid;
    logic [15:0] wake_pid;
    logic        caller_blocked;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_FETCH  = 3'd2,
    S_FETCH2 = 3'd3,
    S_EXEC   = 3'd4
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch request, restart the identifier scan
    logic scan;        // step the scan
    logic fetch_rec;   // read the target entry record
    logic fetch_fifo;  // read the head of the target wait queue
    logic commit;      // write back, load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

[rtl/semtab_ctrl.sv]
`timescale 1ns / 1ps

module semtab_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  semtab_pkg::sts_t  sts,
  output semtab_pkg::cmd_t  cmd
);

  semtab_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      semtab_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = semtab_pkg::S_SCAN;
        end
      end
      semtab_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = semtab_pkg::S_FETCH;
        end
      end
      semtab_pkg::S_FETCH:  state_nxt = semtab_pkg::S_FETCH2;
      semtab_pkg::S_FETCH2: state_nxt = semtab_pkg::S_EXEC;
      semtab_pkg::S_EXEC: begin
        if (out_free) begin
          state_nxt = semtab_pkg::S_IDLE;
        end
      end
      default: state_nxt = semtab_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      semtab_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      semtab_pkg::S_SCAN:   cmd.scan       = 1'b1;
      semtab_pkg::S_FETCH:  cmd.fetch_rec  = 1'b1;
      semtab_pkg::S_FETCH2: cmd.fetch_fifo = 1'b1;
      semtab_pkg::S_EXEC:   cmd.commit     = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= semtab_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/semtab_dp.sv]
`timescale 1ns / 1ps

module semtab_dp #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_WAITERS = 16,
  parameter int PID_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  semtab_pkg::in_item_t  in_data,
  input  semtab_pkg::cmd_t      cmd,
  output semtab_pkg::sts_t      sts,
  output semtab_pkg::out_item_t out_data
);

  localparam int EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SCW = $clog2(NUM_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_WAITERS + 1);
  localparam int HW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int FD  = NUM_ENTRIES * MAX_WAITERS;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

  // request
  semtab_pkg::in_item_t item_r;

  // entry table
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [31:0]            ident_mem [NUM_ENTRIES];
  logic [31:0]            count_mem [NUM_ENTRIES];
  logic [AW-1:0]          att_mem   [NUM_ENTRIES];
  logic [HW-1:0]          head_mem  [NUM_ENTRIES];
  logic [AW-1:0]          wcnt_mem  [NUM_ENTRIES];
  logic [PID_BITS-1:0]    fifo_mem  [FD];

  logic [31:0]         rd_ident_r, rd_count_r;
  logic [AW-1:0]       rd_att_r, rd_wcnt_r;
  logic [HW-1:0]       rd_head_r;
  logic [PID_BITS-1:0] fifo_q_r;

  // scan
  logic [SCW-1:0] scan_addr_r;
  logic           cmp_pend_r;
  logic [EW-1:0]  cmp_idx_r;
  logic           hit_r, free_r;
  logic [EW-1:0]  hit_idx_r, free_idx_r;
  logic           scan_live, hit_now, free_now;

  semtab_pkg::out_item_t out_r, res;

  logic [EW-1:0]   tgt_idx, rec_addr;
  logic            rec_re, rec_we, fifo_we, valid_set, valid_clr;
  logic [31:0]     ident_nxt, count_nxt;
  logic [AW-1:0]   att_nxt, wcnt_nxt;
  logic [HW-1:0]   head_nxt;
  logic [FAW-1:0]  fifo_base, fifo_raddr, fifo_waddr;
  logic [HW+1:0]   slot_sum, head_inc;
  logic [HW-1:0]   slot;
  logic [31:0]     pid_in_wide, pid_out_wide;
  logic [PID_BITS-1:0] pid_st;

  assign scan_live     = scan_addr_r < SCW'(NUM_ENTRIES);
  assign sts.scan_done = !scan_live && !cmp_pend_r;

  assign hit_now  = cmp_pend_r && valid_r[cmp_idx_r] && (rd_ident_r == item_r.sem_id) && !hit_r;
  assign free_now = cmp_pend_r && !valid_r[cmp_idx_r] && !free_r;

  assign tgt_idx  = hit_r ? hit_idx_r : free_idx_r;
  assign rec_addr = cmd.scan ? scan_addr_r[EW-1:0] : tgt_idx;
  assign rec_re   = (cmd.scan && scan_live) || cmd.fetch_rec;

  // wait queue is a ring per entry
  assign fifo_base  = FAW'(tgt_idx) * FAW'(MAX_WAITERS);
  assign fifo_raddr = fifo_base + FAW'(rd_head_r);
  assign slot_sum   = (HW+2)'(rd_head_r) + (HW+2)'(rd_wcnt_r);
  assign slot       = (slot_sum >= (HW+2)'(MAX_WAITERS)) ?
                      HW'(slot_sum - (HW+2)'(MAX_WAITERS)) : HW'(slot_sum);
  assign fifo_waddr = fifo_base + FAW'(slot);
  assign head_inc   = (HW+2)'(rd_head_r) + (HW+2)'(1);

  assign pid_in_wide  = 32'(item_r.caller_pid);
  assign pid_st       = pid_in_wide[PID_BITS-1:0];
  assign pid_out_wide = 32'(fifo_q_r);

  always_comb begin
    res       = '0;
    res.status = semtab_pkg::ST_OK;
    rec_we    = 1'b0;
    fifo_we   = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    ident_nxt = rd_ident_r;
    count_nxt = rd_count_r;
    att_nxt   = rd_att_r;
    wcnt_nxt  = rd_wcnt_r;
    head_nxt  = rd_head_r;
    if (item_r.kind == semtab_pkg::KIND_OPEN) begin
      if (!hit_r && !free_r) begin
        res.status = semtab_pkg::ST_TABLE_FULL;
      end else if (!hit_r) begin
        ident_nxt     = item_r.sem_id;
        count_nxt     = item_r.init_value;
        att_nxt       = AW'(1);
        wcnt_nxt      = '0;
        head_nxt      = '0;
        rec_we        = 1'b1;
        valid_set     = 1'b1;
        res.handle_id = item_r.sem_id;
      end else if (rd_att_r >= AW'(MAX_WAITERS)) begin
        res.status = semtab_pkg::ST_ATTACH_LIMIT;
      end else begin
        att_nxt       = rd_att_r + AW'(1);
        rec_we        = 1'b1;
        res.handle_id = item_r.sem_id;
      end
    end else if (!hit_r) begin
      res.status = semtab_pkg::ST_NOT_FOUND;
    end else begin
      case (item_r.kind)
        semtab_pkg::KIND_CLOSE: begin
          if (rd_att_r <= AW'(1)) begin
            valid_clr = 1'b1;
          end else begin
            att_nxt = rd_att_r - AW'(1);
            rec_we  = 1'b1;
          end
        end
        semtab_pkg::KIND_POST: begin
          if (rd_wcnt_r != '0) begin
            res.wake_valid = 1'b1;
            res.wake_pid   = pid_out_wide[15:0];
            head_nxt       = (head_inc == (HW+2)'(MAX_WAITERS)) ? '0 : HW'(head_inc);
            wcnt_nxt       = rd_wcnt_r - AW'(1);
            rec_we         = 1'b1;
          end else if (rd_count_r != 32'hFFFF_FFFF) begin
            count_nxt = rd_count_r + 32'd1;
            rec_we    = 1'b1;
          end
        end
        semtab_pkg::KIND_WAIT: begin
          if (rd_count_r != '0) begin
            count_nxt = rd_count_r - 32'd1;
            rec_we    = 1'b1;
          end else if (rd_wcnt_r >= AW'(MAX_WAITERS)) begin
            res.status = semtab_pkg::ST_QUEUE_FULL;
          end else begin
            fifo_we            = 1'b1;
            wcnt_nxt           = rd_wcnt_r + AW'(1);
            rec_we             = 1'b1;
            res.caller_blocked = 1'b1;
          end
        end
        default: res.status = semtab_pkg::ST_OK;
      endcase
    end
  end

  // entry record store
  always_ff @(posedge clk) begin
    if (cmd.commit && rec_we) begin
      ident_mem[tgt_idx] <= ident_nxt;
      count_mem[tgt_idx] <= count_nxt;
      att_mem[tgt_idx]   <= att_nxt;
      head_mem[tgt_idx]  <= head_nxt;
      wcnt_mem[tgt_idx]  <= wcnt_nxt;
    end
    if (rec_re) begin
      rd_ident_r <= ident_mem[rec_addr];
      rd_count_r <= count_mem[rec_addr];
      rd_att_r   <= att_mem[rec_addr];
      rd_head_r  <= head_mem[rec_addr];
      rd_wcnt_r  <= wcnt_mem[rec_addr];
    end
  end

  // wait queue store
  always_ff @(posedge clk) begin
    if (cmd.commit && fifo_we) begin
      fifo_mem[fifo_waddr] <= pid_st;
    end
    if (cmd.fetch_fifo) begin
      fifo_q_r <= fifo_mem[fifo_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      scan_addr_r <= '0;
      cmp_pend_r  <= 1'b0;
      cmp_idx_r   <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      hit_idx_r   <= '0;
      free_idx_r  <= '0;
    end else begin
      if (cmd.load) begin
        scan_addr_r <= '0;
        cmp_pend_r  <= 1'b0;
        hit_r       <= 1'b0;
        free_r      <= 1'b0;
      end else if (cmd.scan) begin
        cmp_pend_r <= scan_live;
        cmp_idx_r  <= scan_addr_r[EW-1:0];
        if (scan_live) begin
          scan_addr_r <= scan_addr_r + SCW'(1);
        end
        if (hit_now) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        if (free_now) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
      if (cmd.commit && valid_set) begin
        valid_r[tgt_idx] <= 1'b1;
      end
      if (cmd.commit && valid_clr) begin
        valid_r[tgt_idx] <= 1'b0;
      end
    end
  end

  assign out_data = out_r;

endmodule

[rtl/counting_semaphore_table.sv]
`timescale 1ns / 1ps

// Channel   Dir  Ports                        Transfer when
// in        in   in_valid/in_ready/in_data    in_valid && in_ready
// out       out  out_valid/out_ready/out_data out_valid && out_ready
//
// One request at a time. After a transfer in, the identifier scan reads one
// table entry per cycle, then the entry record and the wait-queue head are
// fetched in turn and the execute step writes back and loads the result
// register; the next request transfers in the cycle after that at the
// earliest. The scan sets the rate.
// Reset (rst_n low, synchronous) clears only the entry valid bits and control.
// A waiting result sits in the output register; a new request is taken
// meanwhile, and write-back stalls only if the register is still full then.

module counting_semaphore_table #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_WAITERS = 16,
  parameter int PID_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  semtab_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output semtab_pkg::out_item_t out_data
);

  semtab_pkg::cmd_t cmd;
  semtab_pkg::sts_t sts;

  // sequencing: idle -> scan -> fetch record -> fetch queue head -> execute
  semtab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry table, per-entry wait rings, result register
  semtab_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_WAITERS (MAX_WAITERS),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  // a new result only comes out of the execute step, never from idle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in flight");

  // a blocked caller is only reported with an ok status and no wake
  a_blocked_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.caller_blocked) |->
      (out_data.status == semtab_pkg::ST_OK && !out_data.wake_valid))
    else $error("blocked caller with bad status or wake");

endmodule
